[src/lav_pkg.sv]
// Shared constants and types for the look-at view matrix pipeline.
// Used by every module under src; depends on nothing else.
package lav_pkg;

	// Default number of fraction bits in the fixed-point coordinates.
	localparam int FRAC_BITS_DEF = 16;

	// Width of every coordinate at the block boundary.
	localparam int COORD_W = 32;

	// Normalising shifter: working width and number of binary shift steps.
	localparam int NORM_W     = 64;
	localparam int NORM_STEPS = 6;

	// The largest magnitude is brought into [2^29, 2^30) before the length is taken.
	localparam int UNIT_MAG_W = 30;

	// Sum of squares, square root result and square root remainder widths.
	localparam int SQ_W   = 2 * UNIT_MAG_W + 2;
	localparam int ROOT_W = UNIT_MAG_W + 1;
	localparam int REM_W  = ROOT_W + 3;

	// Translation saturation limits.
	localparam logic [COORD_W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

	// Three coordinates of a point or vector.
	typedef logic [2:0][COORD_W-1:0] coord3_t;

endpackage

[src/lav_unitize.sv]
// Pipelined unit-vector unit: normalising shifter, squares, square root and divider.
// Depends on lav_pkg.
module lav_unitize import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int IN_W      = 33,
	parameter int SB_W      = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [2:0][IN_W-1:0]      vin,
	input  logic [SB_W-1:0]           sb_in,
	output logic                      out_valid,
	output logic [2:0][FRAC_BITS+1:0] vout,
	output logic [SB_W-1:0]           sb_out
);

	localparam int OUT_W  = FRAC_BITS + 2;
	localparam int QW     = FRAC_BITS + 1;
	localparam int NUM_W  = UNIT_MAG_W + FRAC_BITS + 1;
	localparam int SQP_W  = 2 * UNIT_MAG_W;
	localparam int DREM_W = ROOT_W;

	// Data that rides alongside the arithmetic once the shifted magnitudes exist.
	typedef struct packed {
		logic [SB_W-1:0]              sb;
		logic [2:0]                   neg;
		logic                         nz;
		logic [2:0][UNIT_MAG_W-1:0]   s;
	} car_t;

	// Normalising shifter stages; entry 0 holds the absolute values.
	logic                   nrm_v_s   [NORM_STEPS+1];
	logic [2:0][NORM_W-1:0] nrm_mag_s [NORM_STEPS+1];
	logic [2:0]             nrm_neg_s [NORM_STEPS+1];
	logic [SB_W-1:0]        nrm_sb_s  [NORM_STEPS+1];
	logic [2:0][NORM_W-1:0] nrm_mag_d [NORM_STEPS];
	logic [IN_W-1:0]        abs_w     [3];

	// Squares.
	logic                   sq_v_s;
	car_t                   sq_car_s;
	logic [2:0][SQP_W-1:0]  sq_prd_s;

	// Square root stages; entry 0 holds the sum of squares.
	logic                   rt_v_s    [ROOT_W+1];
	car_t                   rt_car_s  [ROOT_W+1];
	logic [SQ_W-1:0]        rt_rad_s  [ROOT_W+1];
	logic [REM_W-1:0]       rt_rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]      rt_root_s [ROOT_W+1];
	logic [REM_W-1:0]       rt_rem_d  [ROOT_W];
	logic [ROOT_W-1:0]      rt_root_d [ROOT_W];

	// Divider stages; entry 0 holds the rounded numerators.
	logic                   dv_v_s    [QW+1];
	car_t                   dv_car_s  [QW+1];
	logic [ROOT_W-1:0]      dv_len_s  [QW+1];
	logic [2:0][NUM_W-1:0]  dv_num_s  [QW+1];
	logic [2:0][DREM_W-1:0] dv_rem_s  [QW+1];
	logic [2:0][QW-1:0]     dv_q_s    [QW+1];
	logic [2:0][DREM_W-1:0] dv_rem_d  [QW];
	logic [2:0][QW-1:0]     dv_q_d    [QW];
	logic [2:0][NUM_W-1:0]  num_w;
	logic [2:0][OUT_W-1:0]  q_w;

	// Absolute values of the incoming components.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_w[i] = vin[i][IN_W-1] ? (~vin[i] + 1'b1) : vin[i];
		end
	end

	// Binary normalising shifter: each step shifts all three left when the OR is clear on top.
	always_comb begin
		logic [NORM_W-1:0] orw;
		int                sh;
		logic              hit;
		for (int k = 0; k < NORM_STEPS; k++) begin
			orw = nrm_mag_s[k][0] | nrm_mag_s[k][1] | nrm_mag_s[k][2];
			sh  = 1 << (NORM_STEPS - 1 - k);
			hit = ~|(orw & ~({NORM_W{1'b1}} >> sh));
			for (int i = 0; i < 3; i++) begin
				nrm_mag_d[k][i] = hit ? (nrm_mag_s[k][i] << sh) : nrm_mag_s[k][i];
			end
		end
	end

	// Square root, one result bit per stage.
	always_comb begin
		logic [REM_W-1:0] rem_w;
		logic [REM_W-1:0] trial_w;
		for (int k = 0; k < ROOT_W; k++) begin
			rem_w   = {rt_rem_s[k][REM_W-3:0], 2'(rt_rad_s[k] >> (2 * (ROOT_W - 1 - k)))};
			trial_w = {1'b0, rt_root_s[k], 2'b01};
			if (rem_w >= trial_w) begin
				rt_rem_d[k]  = rem_w - trial_w;
				rt_root_d[k] = {rt_root_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				rt_rem_d[k]  = rem_w;
				rt_root_d[k] = {rt_root_s[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Rounded numerators from the root stage output.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_w[i] = NUM_W'({rt_car_s[ROOT_W].s[i], {FRAC_BITS{1'b0}}})
				+ NUM_W'(rt_root_s[ROOT_W] >> 1);
		end
	end

	// Restoring division, one quotient bit per stage.
	always_comb begin
		logic [DREM_W:0] rem_w;
		for (int k = 0; k < QW; k++) begin
			for (int i = 0; i < 3; i++) begin
				rem_w = {dv_rem_s[k][i], dv_num_s[k][i][QW-1-k]};
				if (rem_w >= {1'b0, dv_len_s[k]}) begin
					dv_rem_d[k][i] = DREM_W'(rem_w - {1'b0, dv_len_s[k]});
					dv_q_d[k][i]   = {dv_q_s[k][i][QW-2:0], 1'b1};
				end else begin
					dv_rem_d[k][i] = DREM_W'(rem_w);
					dv_q_d[k][i]   = {dv_q_s[k][i][QW-2:0], 1'b0};
				end
			end
		end
	end

	// Final quotients widened to the output width.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_w[i] = OUT_W'(dv_q_s[QW][i]);
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NORM_STEPS; k++) begin
				nrm_v_s[k] <= 1'b0;
			end
			sq_v_s <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++) begin
				rt_v_s[k] <= 1'b0;
			end
			for (int k = 0; k <= QW; k++) begin
				dv_v_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			nrm_v_s[0] <= in_valid;
			for (int k = 0; k < NORM_STEPS; k++) begin
				nrm_v_s[k+1] <= nrm_v_s[k];
			end
			sq_v_s    <= nrm_v_s[NORM_STEPS];
			rt_v_s[0] <= sq_v_s;
			for (int k = 0; k < ROOT_W; k++) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
			dv_v_s[0] <= rt_v_s[ROOT_W];
			for (int k = 0; k < QW; k++) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
			out_valid <= dv_v_s[QW];
		end
	end

	// Payload pipeline.
	always_ff @(posedge clk) begin
		if (en) begin
			// Absolute values and signs.
			for (int i = 0; i < 3; i++) begin
				nrm_neg_s[0][i] <= vin[i][IN_W-1];
				nrm_mag_s[0][i] <= NORM_W'(abs_w[i]);
			end
			nrm_sb_s[0] <= sb_in;

			// Normalising shifter.
			for (int k = 0; k < NORM_STEPS; k++) begin
				nrm_mag_s[k+1] <= nrm_mag_d[k];
				nrm_neg_s[k+1] <= nrm_neg_s[k];
				nrm_sb_s[k+1]  <= nrm_sb_s[k];
			end

			// Top bits of the normalised magnitudes and their squares.
			sq_car_s.sb  <= nrm_sb_s[NORM_STEPS];
			sq_car_s.neg <= nrm_neg_s[NORM_STEPS];
			sq_car_s.nz  <= |(nrm_mag_s[NORM_STEPS][0] | nrm_mag_s[NORM_STEPS][1]
				| nrm_mag_s[NORM_STEPS][2]);
			for (int i = 0; i < 3; i++) begin
				sq_car_s.s[i] <= nrm_mag_s[NORM_STEPS][i][NORM_W-1 -: UNIT_MAG_W];
				sq_prd_s[i]   <= SQP_W'(nrm_mag_s[NORM_STEPS][i][NORM_W-1 -: UNIT_MAG_W])
					* SQP_W'(nrm_mag_s[NORM_STEPS][i][NORM_W-1 -: UNIT_MAG_W]);
			end

			// Sum of squares enters the root.
			rt_car_s[0]  <= sq_car_s;
			rt_rad_s[0]  <= SQ_W'(sq_prd_s[0]) + SQ_W'(sq_prd_s[1]) + SQ_W'(sq_prd_s[2]);
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			for (int k = 0; k < ROOT_W; k++) begin
				rt_car_s[k+1]  <= rt_car_s[k];
				rt_rad_s[k+1]  <= rt_rad_s[k];
				rt_rem_s[k+1]  <= rt_rem_d[k];
				rt_root_s[k+1] <= rt_root_d[k];
			end

			// Numerators with half the length added for rounding.
			dv_car_s[0] <= rt_car_s[ROOT_W];
			dv_len_s[0] <= rt_root_s[ROOT_W];
			dv_num_s[0] <= num_w;
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= DREM_W'(num_w[i] >> QW);
				dv_q_s[0][i]   <= '0;
			end
			for (int k = 0; k < QW; k++) begin
				dv_car_s[k+1] <= dv_car_s[k];
				dv_len_s[k+1] <= dv_len_s[k];
				dv_num_s[k+1] <= dv_num_s[k];
				dv_rem_s[k+1] <= dv_rem_d[k];
				dv_q_s[k+1]   <= dv_q_d[k];
			end

			// Signs restored; a zero vector stays zero.
			for (int i = 0; i < 3; i++) begin
				if (!dv_car_s[QW].nz) begin
					vout[i] <= '0;
				end else if (dv_car_s[QW].neg[i]) begin
					vout[i] <= ~q_w[i] + 1'b1;
				end else begin
					vout[i] <= q_w[i];
				end
			end
			sb_out <= dv_car_s[QW].sb;
		end
	end

endmodule

[src/lav_cross.sv]
// Two-stage pipelined cross product r = a x b with a sideband that travels alongside.
// Depends on lav_pkg.
module lav_cross import lav_pkg::*; #(
	parameter int A_W  = COORD_W,
	parameter int B_W  = FRAC_BITS_DEF + 2,
	parameter int SB_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2:0][A_W-1:0]     a,
	input  logic [2:0][B_W-1:0]     b,
	input  logic [SB_W-1:0]         sb_in,
	output logic                    out_valid,
	output logic [2:0][A_W+B_W:0]   r,
	output logic [SB_W-1:0]         sb_out
);

	localparam int P_W = A_W + B_W;

	logic signed [A_W-1:0] a_w [3];
	logic signed [B_W-1:0] b_w [3];
	logic signed [P_W-1:0] prd_s1 [6];
	logic                  v_s1;
	logic [SB_W-1:0]       sb_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_w[i] = a[i];
			b_w[i] = b[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	// Six products, then the three differences.
	always_ff @(posedge clk) begin
		if (en) begin
			prd_s1[0] <= a_w[1] * b_w[2];
			prd_s1[1] <= a_w[2] * b_w[1];
			prd_s1[2] <= a_w[2] * b_w[0];
			prd_s1[3] <= a_w[0] * b_w[2];
			prd_s1[4] <= a_w[0] * b_w[1];
			prd_s1[5] <= a_w[1] * b_w[0];
			sb_s1     <= sb_in;
			r[0]      <= (P_W+1)'(prd_s1[0]) - (P_W+1)'(prd_s1[1]);
			r[1]      <= (P_W+1)'(prd_s1[2]) - (P_W+1)'(prd_s1[3]);
			r[2]      <= (P_W+1)'(prd_s1[4]) - (P_W+1)'(prd_s1[5]);
			sb_out    <= sb_s1;
		end
	end

endmodule

[src/lav_trans.sv]
// Four-stage translation unit: -(axis . eye), rounded half away from zero and saturated.
// Depends on lav_pkg.
module lav_trans import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int A_W       = FRAC_BITS_DEF + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2:0][A_W-1:0] axis,
	input  coord3_t             eye,
	output logic                out_valid,
	output logic [2:0][A_W-1:0] row,
	output logic [COORD_W-1:0]  t
);

	localparam int P_W = A_W + COORD_W;
	localparam int D_W = P_W + 2;
	localparam int R_W = D_W + 1 - FRAC_BITS;

	logic signed [A_W-1:0]     ax_w  [3];
	logic signed [COORD_W-1:0] eye_w [3];
	logic signed [P_W-1:0]     prd_s1 [3];
	logic [2:0][A_W-1:0]       ax_s1, ax_s2, ax_s3;
	logic signed [D_W-1:0]     dot_s2;
	logic                      neg_s3;
	logic [R_W-1:0]            mag_s3;
	logic [D_W-1:0]            abs_w;
	logic [D_W:0]              rnd_w;
	logic [2:0]                v_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax_w[i]  = axis[i];
			eye_w[i] = eye[i];
		end
		abs_w = dot_s2[D_W-1] ? (~dot_s2 + 1'b1) : dot_s2;
		rnd_w = {1'b0, abs_w} + ((D_W+1)'(1) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_q       <= {v_q[1:0], in_valid};
			out_valid <= v_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Products.
			for (int i = 0; i < 3; i++) begin
				prd_s1[i] <= ax_w[i] * eye_w[i];
			end
			ax_s1 <= axis;

			// Dot product.
			dot_s2 <= D_W'(prd_s1[0]) + D_W'(prd_s1[1]) + D_W'(prd_s1[2]);
			ax_s2  <= ax_s1;

			// Magnitude rounded to the output fraction.
			neg_s3 <= dot_s2[D_W-1];
			mag_s3 <= R_W'(rnd_w >> FRAC_BITS);
			ax_s3  <= ax_s2;

			// Negate and saturate.
			if (neg_s3) begin
				t <= (mag_s3 > R_W'(SAT_POS)) ? SAT_POS : COORD_W'(mag_s3);
			end else begin
				t <= (mag_s3 > R_W'(SAT_NEG)) ? SAT_NEG : COORD_W'(~mag_s3 + 1'b1);
			end
			row <= ax_s3;
		end
	end

endmodule

[src/look_at_view_matrix.sv]
// Look-at view matrix. Throughput one camera setup per cycle while the output is not
// stalled; the three unit-vector units, each with a 31-stage square root and a
// (FRAC_BITS+1)-stage divider, set the depth.
// The whole pipeline advances unless a finished result waits at the output.
// Reset (arst_n low) clears every valid bit at once; payload registers are not reset.
module look_at_view_matrix import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] eye_x,
	input  logic signed [COORD_W-1:0] eye_y,
	input  logic signed [COORD_W-1:0] eye_z,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic signed [COORD_W-1:0] up_x,
	input  logic signed [COORD_W-1:0] up_y,
	input  logic signed [COORD_W-1:0] up_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] m00,
	output logic signed [COORD_W-1:0] m01,
	output logic signed [COORD_W-1:0] m02,
	output logic signed [COORD_W-1:0] m03,
	output logic signed [COORD_W-1:0] m10,
	output logic signed [COORD_W-1:0] m11,
	output logic signed [COORD_W-1:0] m12,
	output logic signed [COORD_W-1:0] m13,
	output logic signed [COORD_W-1:0] m20,
	output logic signed [COORD_W-1:0] m21,
	output logic signed [COORD_W-1:0] m22,
	output logic signed [COORD_W-1:0] m23
);

	localparam int U_W   = FRAC_BITS + 2;
	localparam int DIF_W = COORD_W + 1;
	localparam int X_W   = COORD_W + U_W + 1;
	localparam int Y_W   = 2 * U_W + 1;

	typedef logic [2:0][U_W-1:0] unit3_t;

	typedef struct packed {
		coord3_t eye;
		coord3_t up;
	} sb1_t;

	typedef struct packed {
		coord3_t eye;
		unit3_t  d;
	} sb2_t;

	typedef struct packed {
		coord3_t eye;
		unit3_t  d;
		unit3_t  x;
	} sb3_t;

	logic                   en;
	logic                   v_s1;
	coord3_t                eye_s1, up_s1;
	logic [2:0][DIF_W-1:0]  dif_s1;
	sb1_t                   sb1_w, u1_sb;
	sb2_t                   sb2_w, c1_sb, u2_sb;
	sb3_t                   sb3_w, c2_sb, u3_sb;
	logic                   u1_v, c1_v, u2_v, c2_v, u3_v;
	unit3_t                 u1_d, u2_x, u3_y, z_w;
	logic [2:0][X_W-1:0]    c1_x;
	logic [2:0][Y_W-1:0]    c2_y;
	unit3_t                 row_x, row_y, row_z;
	logic [COORD_W-1:0]     t_x, t_y, t_z;

	// The pipeline moves whenever the output register is free or being emptied.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Input stage: view direction before normalising.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eye_s1    <= {eye_z, eye_y, eye_x};
			up_s1     <= {up_z, up_y, up_x};
			dif_s1[0] <= DIF_W'(target_x) - DIF_W'(eye_x);
			dif_s1[1] <= DIF_W'(target_y) - DIF_W'(eye_y);
			dif_s1[2] <= DIF_W'(target_z) - DIF_W'(eye_z);
		end
	end

	// d = unit(target - eye).
	assign sb1_w.eye = eye_s1;
	assign sb1_w.up  = up_s1;

	lav_unitize #(
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (DIF_W),
		.SB_W      ($bits(sb1_t))
	) u_unit_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.vin       (dif_s1),
		.sb_in     (sb1_w),
		.out_valid (u1_v),
		.vout      (u1_d),
		.sb_out    (u1_sb)
	);

	// up x d.
	assign sb2_w.eye = u1_sb.eye;
	assign sb2_w.d   = u1_d;

	lav_cross #(
		.A_W  (COORD_W),
		.B_W  (U_W),
		.SB_W ($bits(sb2_t))
	) u_cross_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u1_v),
		.a         (u1_sb.up),
		.b         (u1_d),
		.sb_in     (sb2_w),
		.out_valid (c1_v),
		.r         (c1_x),
		.sb_out    (c1_sb)
	);

	// Side axis x.
	lav_unitize #(
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (X_W),
		.SB_W      ($bits(sb2_t))
	) u_unit_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c1_v),
		.vin       (c1_x),
		.sb_in     (c1_sb),
		.out_valid (u2_v),
		.vout      (u2_x),
		.sb_out    (u2_sb)
	);

	// d x x.
	assign sb3_w.eye = u2_sb.eye;
	assign sb3_w.d   = u2_sb.d;
	assign sb3_w.x   = u2_x;

	lav_cross #(
		.A_W  (U_W),
		.B_W  (U_W),
		.SB_W ($bits(sb3_t))
	) u_cross_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u2_v),
		.a         (u2_sb.d),
		.b         (u2_x),
		.sb_in     (sb3_w),
		.out_valid (c2_v),
		.r         (c2_y),
		.sb_out    (c2_sb)
	);

	// Up axis y.
	lav_unitize #(
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (Y_W),
		.SB_W      ($bits(sb3_t))
	) u_unit_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c2_v),
		.vin       (c2_y),
		.sb_in     (c2_sb),
		.out_valid (u3_v),
		.vout      (u3_y),
		.sb_out    (u3_sb)
	);

	// Row z is the negated view direction.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			z_w[i] = ~u3_sb.d[i] + 1'b1;
		end
	end

	// Translations; their last stage is the output register.
	lav_trans #(
		.FRAC_BITS (FRAC_BITS),
		.A_W       (U_W)
	) u_trans_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u3_v),
		.axis      (u3_sb.x),
		.eye       (u3_sb.eye),
		.out_valid (out_valid),
		.row       (row_x),
		.t         (t_x)
	);

	lav_trans #(
		.FRAC_BITS (FRAC_BITS),
		.A_W       (U_W)
	) u_trans_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u3_v),
		.axis      (u3_y),
		.eye       (u3_sb.eye),
		.out_valid (),
		.row       (row_y),
		.t         (t_y)
	);

	lav_trans #(
		.FRAC_BITS (FRAC_BITS),
		.A_W       (U_W)
	) u_trans_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u3_v),
		.axis      (z_w),
		.eye       (u3_sb.eye),
		.out_valid (),
		.row       (row_z),
		.t         (t_z)
	);

	// Matrix entries, sign-extended to the port width.
	assign m00 = COORD_W'($signed(row_x[0]));
	assign m01 = COORD_W'($signed(row_x[1]));
	assign m02 = COORD_W'($signed(row_x[2]));
	assign m03 = t_x;
	assign m10 = COORD_W'($signed(row_y[0]));
	assign m11 = COORD_W'($signed(row_y[1]));
	assign m12 = COORD_W'($signed(row_y[2]));
	assign m13 = t_y;
	assign m20 = COORD_W'($signed(row_z[0]));
	assign m21 = COORD_W'($signed(row_z[1]));
	assign m22 = COORD_W'($signed(row_z[2]));
	assign m23 = t_z;

endmodule

[src/lav_check.sv]
// Port-level checker for look_at_view_matrix and the bind that attaches it.
// Depends on lav_pkg and on the top level's port names.
module lav_check import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [COORD_W-1:0] m00,
	input logic signed [COORD_W-1:0] m01,
	input logic signed [COORD_W-1:0] m02,
	input logic signed [COORD_W-1:0] m03,
	input logic signed [COORD_W-1:0] m10,
	input logic signed [COORD_W-1:0] m11,
	input logic signed [COORD_W-1:0] m12,
	input logic signed [COORD_W-1:0] m13,
	input logic signed [COORD_W-1:0] m20,
	input logic signed [COORD_W-1:0] m21,
	input logic signed [COORD_W-1:0] m22,
	input logic signed [COORD_W-1:0] m23
);

	localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(m00) && $stable(m01) && $stable(m02)
		&& $stable(m03) && $stable(m10) && $stable(m11) && $stable(m12)
		&& $stable(m13) && $stable(m20) && $stable(m21) && $stable(m22) && $stable(m23))
		else $error("result payload changed while stalled");

	// The view row is a unit vector or zero, so no component exceeds one.
	a_view_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m20 <= ONE && m20 >= -ONE && m21 <= ONE && m21 >= -ONE
		&& m22 <= ONE && m22 >= -ONE)
		else $error("view row component out of unit range");

	// A zero side axis forces a zero up axis and zero translations for both.
	a_side_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && m00 == 0 && m01 == 0 && m02 == 0 |->
		m03 == 0 && m10 == 0 && m11 == 0 && m12 == 0 && m13 == 0)
		else $error("zero side axis with non-zero up axis");

	// Eye on the target gives zero side and up rows and a zero view translation.
	a_view_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && m20 == 0 && m21 == 0 && m22 == 0 |->
		m00 == 0 && m01 == 0 && m02 == 0 && m10 == 0 && m11 == 0 && m12 == 0
		&& m23 == 0)
		else $error("zero view direction with non-zero rows");

endmodule

bind look_at_view_matrix lav_check #(.FRAC_BITS(FRAC_BITS)) u_lav_check (.*);
